[rtl/core/fse_pkg.sv]
// ----------------------------------------------------------------------------
// Flowshop schedule evaluator package
// Field widths, limits and the operation record passed from front to back.
// ----------------------------------------------------------------------------
package fse_pkg;

   localparam int TIME_W               = 32;
   localparam int DUR_W                = 16;
   localparam int WEIGHT_W             = 8;
   localparam int TARD_W               = 40;
   localparam int SUM_W                = 48;
   localparam int CFG_W                = 5;
   localparam int MAX_MACHINES_DEFAULT = 16;
   localparam int QUEUE_DEPTH          = 2;

   typedef struct packed {
      logic                first_job;
      logic                last_job;
      logic                has_due_date;
      logic                mach_first;
      logic                mach_last;
      logic [DUR_W-1:0]    duration;
      logic [TIME_W-1:0]   release_date;
      logic [TIME_W-1:0]   due_date;
      logic [WEIGHT_W-1:0] tardy_weight;
   } op_type;

endpackage

[rtl/core/fse_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/fse_front.sv]
// ----------------------------------------------------------------------------
// Flowshop evaluator front end
// Holds the machine count register, tracks the machine of each operation
// and tags it as first or last machine of its job before queueing.
// ----------------------------------------------------------------------------
module fse_front #(
   parameter int MAX_MACHINES = fse_pkg::MAX_MACHINES_DEFAULT,
   parameter int MW           = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [fse_pkg::CFG_W-1:0]     csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_first_job,
   input  logic                          req_last_job,
   input  logic [fse_pkg::DUR_W-1:0]     req_duration,
   input  logic [fse_pkg::TIME_W-1:0]    req_release_date,
   input  logic                          req_has_due_date,
   input  logic [fse_pkg::TIME_W-1:0]    req_due_date,
   input  logic [fse_pkg::WEIGHT_W-1:0]  req_tardy_weight,
   input  logic                          q_full,
   output logic                          q_push,
   output fse_pkg::op_type               f_op,
   output logic [MW-1:0]                 f_idx
);

   localparam int NW = ($clog2(MAX_MACHINES + 1) > fse_pkg::CFG_W) ?
                       $clog2(MAX_MACHINES + 1) : fse_pkg::CFG_W;

   logic [fse_pkg::CFG_W-1:0] cfg_ff, cfg_in;
   logic [MW-1:0]             idx_ff, idx_in;
   logic [NW-1:0]             cfg_ext;
   logic [NW-1:0]             n_active;
   logic [NW:0]               idx_plus;
   logic                      mach_last;

   always_comb begin
      cfg_ext = NW'(cfg_ff);
      if (cfg_ext == '0) begin
         n_active = NW'(1);
      end else if (cfg_ext > NW'(MAX_MACHINES)) begin
         n_active = NW'(MAX_MACHINES);
      end else begin
         n_active = cfg_ext;
      end
      idx_plus  = (NW + 1)'(idx_ff) + (NW + 1)'(1);
      mach_last = idx_plus >= {1'b0, n_active};
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      cfg_in = csr_write_enable ? csr_write_data : cfg_ff;
      idx_in = idx_ff;
      if (q_push) begin
         idx_in = mach_last ? '0 : idx_plus[MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= fse_pkg::CFG_W'(1);
         idx_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      f_op.first_job    = req_first_job;
      f_op.last_job     = req_last_job;
      f_op.has_due_date = req_has_due_date;
      f_op.mach_first   = (idx_ff == '0);
      f_op.mach_last    = mach_last;
      f_op.duration     = req_duration;
      f_op.release_date = req_release_date;
      f_op.due_date     = req_due_date;
      f_op.tardy_weight = req_tardy_weight;
   end

   assign f_idx = idx_ff;

endmodule

[rtl/core/fse_queue.sv]
// ----------------------------------------------------------------------------
// Flowshop evaluator operation queue
// Short FIFO between the front end and the execution pipeline.
// ----------------------------------------------------------------------------
module fse_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = fse_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/fse_back.sv]
// ----------------------------------------------------------------------------
// Flowshop evaluator execution pipeline
// Applies the flowshop recurrence against the per-machine end times,
// weighs lateness, keeps the running total and holds the result register.
// ----------------------------------------------------------------------------
module fse_back #(
   parameter int MAX_MACHINES = fse_pkg::MAX_MACHINES_DEFAULT,
   parameter int MW           = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  fse_pkg::op_type               q_op,
   input  logic [MW-1:0]                 q_idx,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fse_pkg::TIME_W-1:0]    rsp_completion_time,
   output logic [fse_pkg::TARD_W-1:0]    rsp_job_tardiness,
   output logic [fse_pkg::SUM_W-1:0]     rsp_total_tardiness,
   output logic [fse_pkg::TIME_W-1:0]    rsp_makespan,
   output logic                          rsp_schedule_done
);

   localparam int TW = fse_pkg::TIME_W;
   localparam int SW = fse_pkg::SUM_W;
   localparam int KW = fse_pkg::TARD_W;

   logic adv;

   // execute stage
   logic                   x_valid_ff;
   fse_pkg::op_type        x_op_ff;
   logic [MW-1:0]          x_idx_ff;
   logic                   byp_ff;
   logic [TW-1:0]          byp_data_ff;
   logic [TW-1:0]          job_prev_ff;
   logic [TW-1:0]          ram_rd_data;
   logic [TW-1:0]          prev_end, other_end, op_start, end_time;
   logic [TW:0]            end_sum;
   logic                   x_write;

   // tardiness stage
   logic                   t_valid_ff;
   logic [TW-1:0]          t_end_ff;
   logic [TW-1:0]          t_due_ff;
   logic                   t_has_due_ff;
   logic [fse_pkg::WEIGHT_W-1:0] t_weight_ff;
   logic                   t_clr_ff, t_rsp_ff, t_last_ff;
   logic [TW-1:0]          t_diff;
   logic [KW-1:0]          t_tard;

   // accumulate stage
   logic                   m_valid_ff;
   logic [KW-1:0]          m_tard_ff;
   logic [TW-1:0]          m_end_ff;
   logic                   m_clr_ff, m_rsp_ff, m_last_ff;
   logic [SW-1:0]          sum_ff, sum_in;
   logic [SW-1:0]          sum_base, sum_sat;
   logic [SW:0]            sum_wide;

   // result register
   logic                   rsp_valid_ff;
   logic [TW-1:0]          rsp_end_ff;
   logic [KW-1:0]          rsp_tard_ff;
   logic [SW-1:0]          rsp_total_ff;
   logic                   rsp_done_ff;

   assign adv   = !(rsp_valid_ff && rsp_stall);
   assign q_pop = adv && q_valid;

   fse_ram #(
      .WIDTH (TW),
      .DEPTH (MAX_MACHINES),
      .AW    (MW)
   ) u_end_ram (
      .clock   (clock),
      .wr_en   (x_write),
      .wr_addr (x_idx_ff),
      .wr_data (end_time),
      .rd_en   (q_pop),
      .rd_addr (q_idx),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (x_op_ff.first_job) begin
         prev_end = '0;
      end else begin
         prev_end = byp_ff ? byp_data_ff : ram_rd_data;
      end
      other_end  = x_op_ff.mach_first ? x_op_ff.release_date : job_prev_ff;
      op_start   = (prev_end > other_end) ? prev_end : other_end;
      end_sum    = {1'b0, op_start} + (TW + 1)'(x_op_ff.duration);
      end_time   = end_sum[TW] ? '1 : end_sum[TW-1:0];
      x_write    = adv && x_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff  <= 1'b0;
         byp_ff      <= 1'b0;
         job_prev_ff <= '0;
      end else if (adv) begin
         x_valid_ff <= q_valid;
         byp_ff     <= q_valid && x_valid_ff && (q_idx == x_idx_ff);
         if (x_valid_ff) begin
            job_prev_ff <= end_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_op_ff     <= q_op;
         x_idx_ff    <= q_idx;
         byp_data_ff <= end_time;
      end
   end

   always_comb begin
      t_diff = t_end_ff - t_due_ff;
      if (t_has_due_ff && (t_end_ff > t_due_ff)) begin
         t_tard = KW'(t_diff) * KW'(t_weight_ff);
      end else begin
         t_tard = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else if (adv) begin
         t_valid_ff <= x_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_end_ff     <= end_time;
         t_due_ff     <= x_op_ff.due_date;
         t_has_due_ff <= x_op_ff.has_due_date;
         t_weight_ff  <= x_op_ff.tardy_weight;
         t_clr_ff     <= x_op_ff.first_job && x_op_ff.mach_first;
         t_rsp_ff     <= x_op_ff.mach_last;
         t_last_ff    <= x_op_ff.last_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= t_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_tard_ff <= t_tard;
         m_end_ff  <= t_end_ff;
         m_clr_ff  <= t_clr_ff;
         m_rsp_ff  <= t_rsp_ff;
         m_last_ff <= t_last_ff;
      end
   end

   always_comb begin
      sum_base = m_clr_ff ? '0 : sum_ff;
      sum_wide = {1'b0, sum_base} + (SW + 1)'(m_tard_ff);
      sum_sat  = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
      sum_in   = sum_ff;
      if (adv && m_valid_ff) begin
         sum_in = m_rsp_ff ? sum_sat : sum_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         if (adv) begin
            rsp_valid_ff <= m_valid_ff && m_rsp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && m_valid_ff && m_rsp_ff) begin
         rsp_end_ff   <= m_end_ff;
         rsp_tard_ff  <= m_tard_ff;
         rsp_total_ff <= sum_sat;
         rsp_done_ff  <= m_last_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_completion_time = rsp_end_ff;
   assign rsp_job_tardiness   = rsp_tard_ff;
   assign rsp_total_tardiness = rsp_total_ff;
   assign rsp_makespan        = rsp_end_ff;
   assign rsp_schedule_done   = rsp_done_ff;

endmodule

[rtl/core/flowshop_schedule_evaluator_core.sv]
// ----------------------------------------------------------------------------
// Flowshop schedule evaluator
// Streams job operations through the permutation flowshop recurrence and
// reports completion, weighted tardiness, running total and makespan.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  one operation of a job
//   rsp      out        rsp_valid / rsp_stall  one result per completed job
//   csr      in         csr_write_enable       machines in use
//
// One operation per cycle sustained unless rsp_stall holds a result; the
// end-time update of the execute stage, one read-modify-write of the
// per-machine end-time RAM, sets it. A result goes through the queue and
// the execute, tardiness, accumulate and result registers. Reset is
// synchronous; end times need no clearing pass. req_stall rises only when
// the two-entry queue is full; rsp_stall on a result holds the pipeline.
// ----------------------------------------------------------------------------
module flowshop_schedule_evaluator_core #(
   parameter int MAX_MACHINES = fse_pkg::MAX_MACHINES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [fse_pkg::CFG_W-1:0]     csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_first_job,
   input  logic                          req_last_job,
   input  logic [fse_pkg::DUR_W-1:0]     req_duration,
   input  logic [fse_pkg::TIME_W-1:0]    req_release_date,
   input  logic                          req_has_due_date,
   input  logic [fse_pkg::TIME_W-1:0]    req_due_date,
   input  logic [fse_pkg::WEIGHT_W-1:0]  req_tardy_weight,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fse_pkg::TIME_W-1:0]    rsp_completion_time,
   output logic [fse_pkg::TARD_W-1:0]    rsp_job_tardiness,
   output logic [fse_pkg::SUM_W-1:0]     rsp_total_tardiness,
   output logic [fse_pkg::TIME_W-1:0]    rsp_makespan,
   output logic                          rsp_schedule_done
);

   localparam int MW  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
   localparam int OPW = $bits(fse_pkg::op_type);
   localparam int QW  = OPW + MW;

   logic            q_full, q_push, q_pop, q_valid;
   fse_pkg::op_type f_op, q_op;
   logic [MW-1:0]   f_idx, q_idx;
   logic [QW-1:0]   q_word;

   fse_front #(
      .MAX_MACHINES (MAX_MACHINES),
      .MW           (MW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_job    (req_first_job),
      .req_last_job     (req_last_job),
      .req_duration     (req_duration),
      .req_release_date (req_release_date),
      .req_has_due_date (req_has_due_date),
      .req_due_date     (req_due_date),
      .req_tardy_weight (req_tardy_weight),
      .q_full           (q_full),
      .q_push           (q_push),
      .f_op             (f_op),
      .f_idx            (f_idx)
   );

   fse_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_idx, f_op}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_word)
   );

   assign q_op  = fse_pkg::op_type'(q_word[OPW-1:0]);
   assign q_idx = q_word[OPW +: MW];

   fse_back #(
      .MAX_MACHINES (MAX_MACHINES),
      .MW           (MW)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_op                (q_op),
      .q_idx               (q_idx),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_completion_time (rsp_completion_time),
      .rsp_job_tardiness   (rsp_job_tardiness),
      .rsp_total_tardiness (rsp_total_tardiness),
      .rsp_makespan        (rsp_makespan),
      .rsp_schedule_done   (rsp_schedule_done)
   );

`ifndef SYNTHESIS
   a_pop_needs_entry : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_machine_wrap : assert property (@(posedge clock) disable iff (reset)
      (q_push && f_op.mach_last) |=> (f_idx == '0))
      else $error("machine index did not wrap after last machine");

   a_total_covers_job : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_job_tardiness != '0)) |-> (rsp_total_tardiness != '0))
      else $error("running total misses job tardiness");
`endif

endmodule

[tb/flowshop_schedule_evaluator_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flowshop schedule evaluator checker
// Watches the configuration port and both channels of the evaluator core.
// On each accepted operation it steps its own copy of the flowshop
// recurrence. Each completed job queues an expected result. Each result
// transfer is compared field by field with the oldest queued expectation.
// ----------------------------------------------------------------------------
module flowshop_schedule_evaluator_checker #(
   parameter int MAX_MACHINES = fse_pkg::MAX_MACHINES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [fse_pkg::CFG_W-1:0]     csr_write_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_first_job,
   input  logic                          req_last_job,
   input  logic [fse_pkg::DUR_W-1:0]     req_duration,
   input  logic [fse_pkg::TIME_W-1:0]    req_release_date,
   input  logic                          req_has_due_date,
   input  logic [fse_pkg::TIME_W-1:0]    req_due_date,
   input  logic [fse_pkg::WEIGHT_W-1:0]  req_tardy_weight,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [fse_pkg::TIME_W-1:0]    rsp_completion_time,
   input  logic [fse_pkg::TARD_W-1:0]    rsp_job_tardiness,
   input  logic [fse_pkg::SUM_W-1:0]     rsp_total_tardiness,
   input  logic [fse_pkg::TIME_W-1:0]    rsp_makespan,
   input  logic                          rsp_schedule_done,
   output int                            mismatch_count,
   output int                            pending_results
);

   typedef struct packed {
      logic [fse_pkg::TIME_W-1:0] completion_time;
      logic [fse_pkg::TARD_W-1:0] job_tardiness;
      logic [fse_pkg::SUM_W-1:0]  total_tardiness;
      logic [fse_pkg::TIME_W-1:0] makespan;
      logic                       schedule_done;
   } job_result_type;

   job_result_type             predicted_job_results [$];
   logic [fse_pkg::CFG_W-1:0]  machines_setting;
   logic [fse_pkg::TIME_W-1:0] machine_busy_until [MAX_MACHINES];
   logic [fse_pkg::TIME_W-1:0] job_last_end;
   int unsigned                current_machine;
   logic [fse_pkg::SUM_W-1:0]  schedule_tardiness;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 100)
         $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_job_result();
      job_result_type want;
      if (predicted_job_results.size() == 0) begin
         report_mismatch("unexpected result transfer", 64'(rsp_completion_time), '0);
      end else begin
         want = predicted_job_results.pop_front();
         if (rsp_completion_time !== want.completion_time)
            report_mismatch("completion_time", 64'(rsp_completion_time),
                            64'(want.completion_time));
         if (rsp_job_tardiness !== want.job_tardiness)
            report_mismatch("job_tardiness", 64'(rsp_job_tardiness),
                            64'(want.job_tardiness));
         if (rsp_total_tardiness !== want.total_tardiness)
            report_mismatch("total_tardiness", 64'(rsp_total_tardiness),
                            64'(want.total_tardiness));
         if (rsp_makespan !== want.makespan)
            report_mismatch("makespan", 64'(rsp_makespan), 64'(want.makespan));
         if (rsp_schedule_done !== want.schedule_done)
            report_mismatch("schedule_done", 64'(rsp_schedule_done),
                            64'(want.schedule_done));
      end
   endtask

   task automatic advance_schedule();
      int unsigned                active_count;
      int unsigned                m;
      logic [fse_pkg::TIME_W-1:0] prior_end;
      logic [fse_pkg::TIME_W-1:0] start_at;
      logic [fse_pkg::TIME_W-1:0] end_at;
      logic [fse_pkg::TIME_W:0]   end_wide;
      logic [fse_pkg::TARD_W-1:0] lateness;
      logic [fse_pkg::SUM_W:0]    sum_wide;
      job_result_type             r;
      active_count = 32'(machines_setting);
      if (active_count == 0)
         active_count = 1;
      if (active_count > MAX_MACHINES)
         active_count = MAX_MACHINES;
      m = (current_machine >= MAX_MACHINES) ? MAX_MACHINES - 1 : current_machine;
      prior_end = req_first_job ? '0 : machine_busy_until[m];
      if (m == 0) begin
         start_at = (prior_end > req_release_date) ? prior_end : req_release_date;
         if (req_first_job)
            schedule_tardiness = '0;
      end else begin
         start_at = (prior_end > job_last_end) ? prior_end : job_last_end;
      end
      end_wide = {1'b0, start_at} + (fse_pkg::TIME_W+1)'(req_duration);
      end_at = end_wide[fse_pkg::TIME_W] ? '1 : end_wide[fse_pkg::TIME_W-1:0];
      machine_busy_until[m] = end_at;
      job_last_end = end_at;
      if (m + 1 < active_count) begin
         current_machine = m + 1;
      end else begin
         current_machine = 0;
         lateness = '0;
         if (req_has_due_date && end_at > req_due_date)
            lateness = fse_pkg::TARD_W'(end_at - req_due_date) *
                       fse_pkg::TARD_W'(req_tardy_weight);
         sum_wide = {1'b0, schedule_tardiness} + (fse_pkg::SUM_W+1)'(lateness);
         schedule_tardiness = sum_wide[fse_pkg::SUM_W] ? '1 :
                              sum_wide[fse_pkg::SUM_W-1:0];
         r.completion_time = end_at;
         r.job_tardiness   = lateness;
         r.total_tardiness = schedule_tardiness;
         r.makespan        = end_at;
         r.schedule_done   = req_last_job;
         predicted_job_results.insert(predicted_job_results.size(), r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mismatch_count   = 0;
         machines_setting = fse_pkg::CFG_W'(1);
         foreach (machine_busy_until[i])
            machine_busy_until[i] = '0;
         job_last_end       = '0;
         current_machine    = 0;
         schedule_tardiness = '0;
         predicted_job_results.delete();
      end else begin
         if (csr_write_enable)
            machines_setting = csr_write_data;
         if (rsp_valid && !rsp_stall)
            check_job_result();
         if (req_valid && !req_stall)
            advance_schedule();
      end
      pending_results = predicted_job_results.size();
   end

endmodule

[tb/flowshop_schedule_evaluator_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flowshop schedule evaluator testbench
// Drives directed operations and then random schedules of jobs through the
// evaluator core under several machine counts and idling patterns, with a
// checker beside the core predicting and comparing every result transfer.
// ----------------------------------------------------------------------------
module flowshop_schedule_evaluator_core_tb;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_write_enable;
   logic [fse_pkg::CFG_W-1:0]    csr_write_data;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_first_job;
   logic                         req_last_job;
   logic [fse_pkg::DUR_W-1:0]    req_duration;
   logic [fse_pkg::TIME_W-1:0]   req_release_date;
   logic                         req_has_due_date;
   logic [fse_pkg::TIME_W-1:0]   req_due_date;
   logic [fse_pkg::WEIGHT_W-1:0] req_tardy_weight;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [fse_pkg::TIME_W-1:0]   rsp_completion_time;
   logic [fse_pkg::TARD_W-1:0]   rsp_job_tardiness;
   logic [fse_pkg::SUM_W-1:0]    rsp_total_tardiness;
   logic [fse_pkg::TIME_W-1:0]   rsp_makespan;
   logic                         rsp_schedule_done;

   int mismatch_count;
   int pending_results;

   int                                     sender_idle_pct    = 0;
   int                                     receiver_stall_pct = 0;
   int unsigned                            next_machine       = 0;
   int unsigned                            machines_active    = 1;
   int unsigned                            ops_sent           = 0;
   bit [fse_pkg::MAX_MACHINES_DEFAULT-1:0] machine_written    = '0;

   flowshop_schedule_evaluator_core dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_first_job       (req_first_job),
      .req_last_job        (req_last_job),
      .req_duration        (req_duration),
      .req_release_date    (req_release_date),
      .req_has_due_date    (req_has_due_date),
      .req_due_date        (req_due_date),
      .req_tardy_weight    (req_tardy_weight),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_completion_time (rsp_completion_time),
      .rsp_job_tardiness   (rsp_job_tardiness),
      .rsp_total_tardiness (rsp_total_tardiness),
      .rsp_makespan        (rsp_makespan),
      .rsp_schedule_done   (rsp_schedule_done)
   );

   flowshop_schedule_evaluator_checker result_check (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_first_job       (req_first_job),
      .req_last_job        (req_last_job),
      .req_duration        (req_duration),
      .req_release_date    (req_release_date),
      .req_has_due_date    (req_has_due_date),
      .req_due_date        (req_due_date),
      .req_tardy_weight    (req_tardy_weight),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_completion_time (rsp_completion_time),
      .rsp_job_tardiness   (rsp_job_tardiness),
      .rsp_total_tardiness (rsp_total_tardiness),
      .rsp_makespan        (rsp_makespan),
      .rsp_schedule_done   (rsp_schedule_done),
      .mismatch_count      (mismatch_count),
      .pending_results     (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct    = 46;
            receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 46;
         end
         default: begin
            sender_idle_pct    = 8;
            receiver_stall_pct = 8;
         end
      endcase
   endtask

   // Drain results and in-flight operations before touching the register.
   task automatic set_machines(input logic [fse_pkg::CFG_W-1:0] value);
      req_valid          = 1'b0;
      receiver_stall_pct = 0;
      while (pending_results != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (value == 0)
         machines_active = 1;
      else if (value > fse_pkg::MAX_MACHINES_DEFAULT)
         machines_active = fse_pkg::MAX_MACHINES_DEFAULT;
      else
         machines_active = 32'(value);
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic issue_op(input bit first, input bit last,
                           input logic [fse_pkg::DUR_W-1:0] dur,
                           input logic [fse_pkg::TIME_W-1:0] rel, input bit has_due,
                           input logic [fse_pkg::TIME_W-1:0] due,
                           input logic [fse_pkg::WEIGHT_W-1:0] w);
      if (!machine_written[next_machine])
         first = 1'b1;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_first_job    = first;
      req_last_job     = last;
      req_duration     = dur;
      req_release_date = rel;
      req_has_due_date = has_due;
      req_due_date     = due;
      req_tardy_weight = w;
      req_valid        = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      machine_written[next_machine] = 1'b1;
      next_machine = (next_machine + 1 < machines_active) ? next_machine + 1 : 0;
      ops_sent++;
      @(negedge clock);
   endtask

   function automatic logic [fse_pkg::DUR_W-1:0] pick_duration();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return fse_pkg::DUR_W'($urandom);
         default: return fse_pkg::DUR_W'($urandom_range(1, 300));
      endcase
   endfunction

   task automatic run_schedule(input int jobs, input bit heavy);
      int                           j;
      int                           op;
      int                           cut_after;
      bit                           cut;
      bit                           first;
      bit                           last;
      bit                           has_due;
      bit                           op_has_due;
      logic [fse_pkg::TIME_W-1:0]   rel;
      logic [fse_pkg::TIME_W-1:0]   due;
      logic [fse_pkg::TIME_W-1:0]   op_rel;
      logic [fse_pkg::TIME_W-1:0]   op_due;
      logic [fse_pkg::WEIGHT_W-1:0] w;
      logic [fse_pkg::WEIGHT_W-1:0] op_w;
      logic [fse_pkg::DUR_W-1:0]    dur;
      cut       = !heavy && ($urandom_range(0, 19) == 0);
      cut_after = $urandom_range(1, machines_active);
      for (j = 0; j < jobs; j++) begin
         if (heavy) begin
            rel     = {16'hFFFF, 16'($urandom)};
            due     = $urandom_range(0, 1000);
            w       = fse_pkg::WEIGHT_W'($urandom_range(250, 255));
            has_due = 1'b1;
         end else begin
            case ($urandom_range(0, 9))
               0:       rel = $urandom;
               1:       rel = '0;
               default: rel = $urandom_range(0, 500 * (j + 1));
            endcase
            case ($urandom_range(0, 7))
               0:       due = $urandom;
               1:       due = '0;
               2:       due = '1;
               default: due = rel + $urandom_range(0, 300 * (machines_active + j));
            endcase
            w       = fse_pkg::WEIGHT_W'($urandom);
            has_due = ($urandom_range(0, 3) != 0);
         end
         op = 0;
         do begin
            first      = (j == 0);
            last       = (j == jobs - 1);
            op_rel     = rel;
            op_due     = due;
            op_w       = w;
            op_has_due = has_due;
            if (!heavy && $urandom_range(0, 11) == 0) begin
               first      = $urandom_range(0, 1);
               last       = $urandom_range(0, 1);
               op_rel     = $urandom;
               op_due     = $urandom;
               op_w       = fse_pkg::WEIGHT_W'($urandom);
               op_has_due = $urandom_range(0, 1);
            end
            dur = heavy ? fse_pkg::DUR_W'($urandom) : pick_duration();
            issue_op(first, last, dur, op_rel, op_has_due, op_due, op_w);
            op++;
            if (cut && j == jobs - 1 && op >= cut_after)
               break;
         end while (next_machine != 0);
      end
   endtask

   initial begin
      int          k;
      int          phase;
      int unsigned phase_start;
      int          drain_guard;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_first_job    = 1'b0;
      req_last_job     = 1'b0;
      req_duration     = '0;
      req_release_date = '0;
      req_has_due_date = 1'b0;
      req_due_date     = '0;
      req_tardy_weight = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // one machine from reset: zero times, saturation, due at the top of range
      issue_op(1'b1, 1'b0, '0, '0, 1'b0, '0, '0);
      issue_op(1'b0, 1'b0, '1, '1, 1'b1, '0, '1);
      issue_op(1'b0, 1'b0, 16'd5, '0, 1'b1, '1, '1);
      issue_op(1'b0, 1'b1, 16'h1234, '0, 1'b1, '0, 8'd1);
      issue_op(1'b1, 1'b0, 16'd10, 32'd100, 1'b0, '0, '0);
      issue_op(1'b0, 1'b0, 16'd7, 32'd50, 1'b1, 32'd200, 8'd3);

      set_machines(fse_pkg::CFG_W'(0));
      issue_op(1'b1, 1'b1, 16'd3, 32'd20, 1'b1, 32'd10, 8'd4);
      issue_op(1'b0, 1'b0, 16'd9, 32'd5, 1'b1, 32'd40, 8'd2);

      set_machines('1);
      for (k = 0; k < fse_pkg::MAX_MACHINES_DEFAULT; k++)
         issue_op(1'b1, k == fse_pkg::MAX_MACHINES_DEFAULT - 1, pick_duration(),
                  32'd1000, 1'b1, 32'd1100, 8'd2);

      // shrink the machine count part-way through a job
      set_machines(fse_pkg::CFG_W'(3));
      issue_op(1'b1, 1'b0, 16'd40, 32'd7, 1'b1, 32'd10, 8'd9);
      set_machines(fse_pkg::CFG_W'(1));
      issue_op(1'b0, 1'b1, 16'd40, 32'd7, 1'b1, 32'd10, 8'd9);

      for (phase = 0; ops_sent < 1850; phase++) begin
         if (phase == 5) begin
            set_machines(fse_pkg::CFG_W'(1));
            set_idling(idle_mode_type'(phase % 4));
            run_schedule(300, 1'b1);
         end else begin
            case (phase % 8)
               0:       set_machines(fse_pkg::CFG_W'(fse_pkg::MAX_MACHINES_DEFAULT));
               1:       set_machines(fse_pkg::CFG_W'(1));
               2:       set_machines(fse_pkg::CFG_W'(2));
               3:       set_machines(fse_pkg::CFG_W'($urandom_range(3, 15)));
               4:       set_machines(fse_pkg::CFG_W'(0));
               5:       set_machines(fse_pkg::CFG_W'($urandom_range(17, 31)));
               6:       set_machines(fse_pkg::CFG_W'(4));
               default: set_machines(fse_pkg::CFG_W'($urandom_range(1, 16)));
            endcase
            set_idling(idle_mode_type'(phase % 4));
            phase_start = ops_sent;
            while (ops_sent - phase_start < 140)
               run_schedule($urandom_range(1, 8), 1'b0);
         end
      end

      req_valid          = 1'b0;
      receiver_stall_pct = 0;
      drain_guard        = 0;
      while (pending_results != 0 && drain_guard < 10000) begin
         @(negedge clock);
         drain_guard++;
      end
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pending_results == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
